### rtl/core/rncd_pkg.sv
`timescale 1ns / 1ps

package rncd_pkg;

    localparam int MAX_CODES  = 1024;
    localparam int CODE_WIDTH = 64;
    localparam int IDX_W      = $clog2(MAX_CODES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int DIST_W     = 7;
    localparam int NUM_ROT    = 4;
    localparam int NUM_CELLS  = 4;

    localparam logic [1:0] CFG_GRID_SIDE = 2'd0;
    localparam logic [1:0] CFG_CODES     = 2'd1;
    localparam logic [1:0] CFG_RECOVERY  = 2'd2;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_DECODE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ROTATE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Running best match carried from cell to cell.
    typedef struct packed {
        logic                  have;
        logic [IDX_W-1:0]      index;
        logic [DIST_W-1:0]     distance;
        logic [1:0]            rotation;
        logic [CODE_WIDTH-1:0] code;
    } best_t;

    function automatic logic [CODE_WIDTH-1:0] turn_quarter(
        input logic [CODE_WIDTH-1:0] w,
        input logic [3:0]            d
    );
        logic [63:0] src;
        logic [63:0] res;
        int          k;
        src = 64'(w);
        res = '0;
        for (int r = 0; r < 8; r++) begin
            for (int c = 0; c < 8; c++) begin
                if (r < int'(d) && c < int'(d)) begin
                    // output position counted from the most recent shift
                    k = (r * int'(d)) + (int'(d) - 1 - c);
                    res[k] = src[r + int'(d) * c];
                end
            end
        end
        return res[CODE_WIDTH-1:0];
    endfunction

endpackage

### rtl/core/rncd_ram.sv
`timescale 1ns / 1ps

module rncd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/rncd_cell.sv
`timescale 1ns / 1ps

// One compare cell: distance of the entry to one rotation, merge into the
// running best, and pass entry and best on to the next cell.
module rncd_cell (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    input  logic [rncd_pkg::IDX_W-1:0]           in_index,
    input  logic [rncd_pkg::CODE_WIDTH-1:0]      in_entry,
    input  rncd_pkg::best_t                      in_best,
    input  logic [rncd_pkg::CODE_WIDTH-1:0]      view,
    input  logic [1:0]                           rot,
    output logic                                 out_valid,
    output logic [rncd_pkg::IDX_W-1:0]           out_index,
    output logic [rncd_pkg::CODE_WIDTH-1:0]      out_entry,
    output rncd_pkg::best_t                      out_best
);

    logic [rncd_pkg::DIST_W-1:0]      ham_dist;
    rncd_pkg::best_t                  best_next;
    logic                             valid_reg;
    logic [rncd_pkg::IDX_W-1:0]       index_reg;
    logic [rncd_pkg::CODE_WIDTH-1:0]  entry_reg;
    rncd_pkg::best_t                  best_reg;

    always_comb
    begin
        ham_dist = rncd_pkg::DIST_W'($countones(view ^ in_entry));
        best_next = in_best;
        if (in_valid && (!in_best.have || ham_dist < in_best.distance))
        begin
            best_next.have     = 1'b1;
            best_next.index    = in_index;
            best_next.distance = ham_dist;
            best_next.rotation = rot;
            best_next.code     = in_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        index_reg <= in_index;
        entry_reg <= in_entry;
        best_reg  <= best_next;
    end

    assign out_valid = valid_reg;
    assign out_index = index_reg;
    assign out_entry = entry_reg;
    assign out_best  = best_reg;

endmodule

### rtl/core/rotated_nearest_codeword_decode_top.sv
`timescale 1ns / 1ps
// Load beat: written into the table at the accepting edge, no result beat.
// Decode beat: the three turned views are built, then the first N entries are
// scanned, N = codes_in_use capped at 1024, one entry at a time since the running
// best loops once around the four-cell chain per entry; then the chain drains.
// One beat at a time: a new beat is taken only when idle and no result waits.
// Reset (async, active low) clears control and loads register defaults.
module rotated_nearest_codeword_decode_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [9:0]  entry_index,
    input  logic [63:0] code_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [9:0]  best_index,
    output logic [6:0]  best_distance,
    output logic [1:0]  best_rotation,
    output logic        accepted,
    output logic [63:0] matched_code
);

    localparam int CW = rncd_pkg::CODE_WIDTH;
    localparam int IW = rncd_pkg::IDX_W;
    localparam int NW = rncd_pkg::CNT_W;

    // Configuration registers.
    logic [3:0]  grid_side_reg;
    logic [10:0] codes_reg;
    logic [6:0]  recovery_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_side_reg <= 4'd6;
            codes_reg     <= 11'd0;
            recovery_reg  <= 7'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rncd_pkg::CFG_GRID_SIDE: grid_side_reg <= cfg_data[3:0];
                rncd_pkg::CFG_CODES:     codes_reg     <= cfg_data;
                rncd_pkg::CFG_RECOVERY:  recovery_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    rncd_pkg::state_t state_reg, state_next;
    logic [1:0]    rot_cnt_reg, rot_cnt_next;
    logic [NW-1:0] addr_reg, addr_next;
    logic [NW-1:0] limit_reg, limit_next;
    logic [2:0]    drain_reg, drain_next;
    logic          rd_valid_reg, rd_valid_next;
    logic [IW-1:0] rd_index_reg;
    logic [CW-1:0] views_reg [rncd_pkg::NUM_ROT];
    logic [CW-1:0] views_next [rncd_pkg::NUM_ROT];
    logic          out_valid_reg, out_valid_next;
    rncd_pkg::best_t res_reg;
    logic          load_we;
    logic [3:0]    d_eff;
    logic [CW-1:0] rdata;
    logic          in_fire;
    logic [IW-1:0] ram_raddr;

    assign d_eff    = (grid_side_reg > 4'd8) ? 4'd8 : grid_side_reg;
    assign in_ready = (state_reg == rncd_pkg::ST_IDLE) && !out_valid_reg;
    assign in_fire  = in_valid && in_ready;
    assign load_we  = in_fire && (op == rncd_pkg::OP_LOAD)
                      && (32'(entry_index) < rncd_pkg::MAX_CODES);
    assign ram_raddr = addr_reg[IW-1:0];

    rncd_ram #(.WIDTH(CW), .DEPTH(rncd_pkg::MAX_CODES)) u_table (
        .clk   (clk),
        .we    (load_we),
        .waddr (entry_index[IW-1:0]),
        .wdata (code_bits[CW-1:0]),
        .raddr (ram_raddr),
        .rdata (rdata)
    );

    // Chain of compare cells, one per rotation.
    logic            c_valid [rncd_pkg::NUM_CELLS+1];
    logic [IW-1:0]   c_index [rncd_pkg::NUM_CELLS+1];
    logic [CW-1:0]   c_entry [rncd_pkg::NUM_CELLS+1];
    rncd_pkg::best_t c_best  [rncd_pkg::NUM_CELLS+1];

    assign c_valid[0] = rd_valid_reg;
    assign c_index[0] = rd_index_reg;
    assign c_entry[0] = rdata;
    // Feedback: the last cell's best is the running best for the next entry.
    assign c_best[0]  = (state_reg == rncd_pkg::ST_SCAN && c_valid[rncd_pkg::NUM_CELLS])
                        ? c_best[rncd_pkg::NUM_CELLS] : res_reg;

    for (genvar g = 0; g < rncd_pkg::NUM_CELLS; g++)
    begin : g_cell
        rncd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[g]),
            .in_index  (c_index[g]),
            .in_entry  (c_entry[g]),
            .in_best   (c_best[g]),
            .view      (views_reg[g]),
            .rot       (2'(g)),
            .out_valid (c_valid[g+1]),
            .out_index (c_index[g+1]),
            .out_entry (c_entry[g+1]),
            .out_best  (c_best[g+1])
        );
    end

    // The running best returns from the last cell only after passing all four
    // cell registers; to keep ordering exact the scan waits for it before issuing
    // the next entry, so each entry meets the best of all entries before it.
    logic [1:0] gap_reg, gap_next;

    always_comb
    begin
        state_next     = state_reg;
        rot_cnt_next   = rot_cnt_reg;
        addr_next      = addr_reg;
        limit_next     = limit_reg;
        drain_next     = drain_reg;
        rd_valid_next  = 1'b0;
        out_valid_next = out_valid_reg;
        gap_next       = gap_reg;
        for (int i = 0; i < rncd_pkg::NUM_ROT; i++)
        begin
            views_next[i] = views_reg[i];
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            rncd_pkg::ST_IDLE:
            begin
                if (in_fire && op == rncd_pkg::OP_DECODE)
                begin
                    views_next[0] = code_bits[CW-1:0];
                    rot_cnt_next  = 2'd1;
                    limit_next    = (codes_reg > 11'(rncd_pkg::MAX_CODES))
                                    ? NW'(rncd_pkg::MAX_CODES) : NW'(codes_reg);
                    addr_next     = '0;
                    gap_next      = '0;
                    state_next    = rncd_pkg::ST_ROTATE;
                end
            end
            rncd_pkg::ST_ROTATE:
            begin
                views_next[rot_cnt_reg] =
                    rncd_pkg::turn_quarter(views_reg[rot_cnt_reg - 2'd1], d_eff);
                rot_cnt_next = rot_cnt_reg + 2'd1;
                if (rot_cnt_reg == 2'd3)
                begin
                    state_next = rncd_pkg::ST_SCAN;
                end
            end
            rncd_pkg::ST_SCAN:
            begin
                gap_next = gap_reg + 2'd1;
                if (gap_reg == 2'd0 && addr_reg < limit_reg)
                begin
                    rd_valid_next = 1'b1;
                    addr_next     = addr_reg + NW'(1);
                end
                else if (addr_reg >= limit_reg && gap_reg == 2'd0)
                begin
                    drain_next = 3'd6;
                    state_next = rncd_pkg::ST_DONE;
                end
            end
            rncd_pkg::ST_DONE:
            begin
                drain_next = drain_reg - 3'd1;
                if (drain_reg == 3'd1)
                begin
                    out_valid_next = 1'b1;
                    state_next     = rncd_pkg::ST_IDLE;
                end
            end
            default: state_next = rncd_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rncd_pkg::ST_IDLE;
            rot_cnt_reg   <= '0;
            addr_reg      <= '0;
            limit_reg     <= '0;
            drain_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            gap_reg       <= '0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            rot_cnt_reg   <= rot_cnt_next;
            addr_reg      <= addr_next;
            limit_reg     <= limit_next;
            drain_reg     <= drain_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
            gap_reg       <= gap_next;
            if (state_reg == rncd_pkg::ST_IDLE && in_fire && op == rncd_pkg::OP_DECODE)
            begin
                res_reg <= '0;
            end
            else if (c_valid[rncd_pkg::NUM_CELLS])
            begin
                res_reg <= c_best[rncd_pkg::NUM_CELLS];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_index_reg <= ram_raddr;
        for (int i = 0; i < rncd_pkg::NUM_ROT; i++)
        begin
            views_reg[i] <= views_next[i];
        end
    end

    assign out_valid     = out_valid_reg;
    assign found         = res_reg.have;
    assign best_index    = res_reg.index;
    assign best_distance = res_reg.distance;
    assign best_rotation = res_reg.rotation;
    assign accepted      = res_reg.have && (res_reg.distance <= recovery_reg);
    assign matched_code  = res_reg.code;

    // The result beat only appears when the engine has returned to idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == rncd_pkg::ST_DONE)
        else $error("result beat raised outside the drain step");

    // No new beat is taken while a result is still held.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !in_ready)
        else $error("input taken while result pending");

    // The reported distance never exceeds the code width.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> res_reg.distance <= 7'(CW))
        else $error("distance out of range");

endmodule

### verif/rotated_nearest_codeword_decode_top_tb.sv
`timescale 1ns / 1ps

module rotated_nearest_codeword_decode_top_tb;

    // One input beat as the driver presents it.
    typedef struct {
        logic        op;
        logic [9:0]  idx;
        logic [63:0] code;
    } tag_beat_t;

    // One decode answer, field for field as the block returns it.
    typedef struct {
        logic        found;
        logic [9:0]  index;
        logic [6:0]  distance;
        logic [1:0]  rotation;
        logic        good;
        logic [63:0] code;
    } match_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [10:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        op;
    logic [9:0]  entry_index;
    logic [63:0] code_bits;
    logic        out_valid;
    logic        out_ready;
    logic        found;
    logic [9:0]  best_index;
    logic [6:0]  best_distance;
    logic [1:0]  best_rotation;
    logic        accepted;
    logic [63:0] matched_code;

    rotated_nearest_codeword_decode_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .op            (op),
        .entry_index   (entry_index),
        .code_bits     (code_bits),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .found         (found),
        .best_index    (best_index),
        .best_distance (best_distance),
        .best_rotation (best_rotation),
        .accepted      (accepted),
        .matched_code  (matched_code)
    );

    // Beats waiting for the driver, and decode answers waiting for the monitor.
    tag_beat_t   beat_queue[$];
    match_t      pending_matches[$];

    // Shadow of the codeword table as the block holds it, updated at acceptance.
    logic [63:0] table_shadow[rncd_pkg::MAX_CODES];
    // The generator keeps its own view of the table so that it can build
    // near-miss observations; it also tracks how many leading entries are written.
    logic [63:0] gen_table[rncd_pkg::MAX_CODES];
    int          gen_prefix;

    // Shadow copies of the configuration registers.
    logic [3:0]  side_reg;
    logic [10:0] count_reg;
    logic [6:0]  recov_reg;

    int          error_count;
    bit          quiet;
    bit          beat_taken;
    int          send_gap;
    int          recv_stall;

    always #10 clk = ~clk;

    // Quarter turn of a d-by-d grid: rows are walked from the last down to the
    // first and each row's columns are shifted in, so the grid turns by 90
    // degrees. Bits above d*d are dropped.
    function automatic logic [63:0] quarter_turn(input logic [63:0] w, input int d);
        logic [63:0] res;
        res = '0;
        for (int r = d; r > 0; r--) begin
            for (int c = 0; c < d; c++) begin
                res = {res[62:0], w[(r - 1) + d * c]};
            end
        end
        return res;
    endfunction

    // Exhaustive nearest-codeword search over the active part of the table.
    // A strict less-than keeps the lowest index, then the lowest rotation, on ties.
    function automatic match_t nearest_match(input logic [63:0] observed);
        logic [63:0] views[4];
        match_t      m;
        int          d;
        int          n;
        int          hd;
        d = (side_reg > 8) ? 8 : int'(side_reg);
        n = (count_reg > rncd_pkg::MAX_CODES) ? rncd_pkg::MAX_CODES : int'(count_reg);
        views[0] = observed;
        for (int k = 1; k < 4; k++)
            views[k] = quarter_turn(views[k - 1], d);
        m = '{found: 1'b0, index: '0, distance: '0, rotation: '0, good: 1'b0, code: '0};
        for (int id = 0; id < n; id++) begin
            for (int rot = 0; rot < 4; rot++) begin
                hd = $countones(views[rot] ^ table_shadow[id]);
                if (!m.found || hd < int'(m.distance)) begin
                    m.found    = 1'b1;
                    m.distance = hd[6:0];
                    m.rotation = rot[1:0];
                    m.index    = id[9:0];
                    m.code     = table_shadow[id];
                end
            end
        end
        m.good = m.found && (m.distance <= recov_reg);
        return m;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Input side: record each accepted beat. Loads update the table shadow and
    // decodes queue their predicted answer, in the order the block sees them.
    always @(posedge clk) begin
        if (rst_n && in_valid && in_ready) begin
            beat_taken <= 1'b1;
            if (op == rncd_pkg::OP_LOAD)
                table_shadow[entry_index] = code_bits;
            else
                pending_matches.push_back(nearest_match(code_bits));
        end else begin
            beat_taken <= 1'b0;
        end
    end

    // Driver: changes inputs on the falling edge. A new beat is presented only
    // once the previous one was taken; random gaps are inserted between beats
    // unless the run is in its quiet tail.
    always @(negedge clk) begin
        if (rst_n && (!in_valid || beat_taken)) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end else if (beat_queue.size() > 0) begin
                in_valid    <= 1'b1;
                op          <= beat_queue[0].op;
                entry_index <= beat_queue[0].idx;
                code_bits   <= beat_queue[0].code;
                void'(beat_queue.pop_front());
                if (!quiet && $urandom_range(0, 3) == 0)
                    send_gap <= $urandom_range(1, 4);
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Receiver backpressure, also in random bursts.
    always @(negedge clk) begin
        if (rst_n) begin
            if (recv_stall > 0) begin
                recv_stall <= recv_stall - 1;
                out_ready  <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0)
                    recv_stall <= $urandom_range(1, 4);
            end
        end
    end

    // Monitor: every result beat is checked against the oldest prediction.
    always @(posedge clk) begin
        match_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_matches.size() == 0) begin
                $display("%0t: result beat with no decode outstanding, index %0h",
                         $time, best_index);
                error_count++;
            end else begin
                want = pending_matches.pop_front();
                check_field("found", 64'(want.found), 64'(found));
                check_field("best_index", 64'(want.index), 64'(best_index));
                check_field("best_distance", 64'(want.distance), 64'(best_distance));
                check_field("best_rotation", 64'(want.rotation), 64'(best_rotation));
                check_field("accepted", 64'(want.good), 64'(accepted));
                check_field("matched_code", want.code, matched_code);
            end
        end
    end

    task automatic queue_beat(input logic o, input logic [9:0] idx, input logic [63:0] code);
        tag_beat_t b;
        b.op   = o;
        b.idx  = idx;
        b.code = code;
        beat_queue.push_back(b);
        if (o == rncd_pkg::OP_LOAD) begin
            gen_table[idx] = code;
            while (gen_prefix < rncd_pkg::MAX_CODES && gen_prefix <= int'(idx)
                   && gen_prefix == int'(idx))
                gen_prefix++;
        end
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // A decode that is usually a turned copy of an active entry with a few
    // flipped bits, so that matches, ties and accepts actually occur.
    task automatic queue_decode_near(input int n);
        logic [63:0] w;
        int          d;
        int          turns;
        int          flips;
        d = (side_reg > 8) ? 8 : int'(side_reg);
        if (n == 0 || $urandom_range(0, 5) == 0) begin
            w = rand64();
        end else begin
            w = gen_table[$urandom_range(0, n - 1)];
            turns = $urandom_range(0, 3);
            for (int k = 0; k < turns; k++)
                w = quarter_turn(w, d);
            flips = $urandom_range(0, 5);
            for (int k = 0; k < flips; k++)
                w[$urandom_range(0, 63)] ^= 1'b1;
        end
        queue_beat(rncd_pkg::OP_DECODE, 10'($urandom_range(0, 1023)), w);
    endtask

    // Configuration writes happen only once the block has gone quiet. Loads
    // give no result, so a few extra cycles cover one still in flight.
    task automatic wait_idle();
        while (beat_queue.size() > 0 || in_valid || pending_matches.size() > 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [10:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == rncd_pkg::CFG_GRID_SIDE)
            side_reg = value[3:0];
        else if (idx == rncd_pkg::CFG_CODES)
            count_reg = value;
        else if (idx == rncd_pkg::CFG_RECOVERY)
            recov_reg = value[6:0];
    endtask

    task automatic set_phase(input int side, input int count, input int recov);
        wait_idle();
        write_reg(rncd_pkg::CFG_GRID_SIDE, side[10:0]);
        write_reg(rncd_pkg::CFG_CODES, count[10:0]);
        write_reg(rncd_pkg::CFG_RECOVERY, recov[10:0]);
    endtask

    initial begin
        int n;
        int side;
        clk         = 1'b0;
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = rncd_pkg::CFG_GRID_SIDE;
        cfg_data    = '0;
        in_valid    = 1'b0;
        op          = rncd_pkg::OP_LOAD;
        entry_index = '0;
        code_bits   = '0;
        out_ready   = 1'b0;
        error_count = 0;
        quiet       = 1'b0;
        beat_taken  = 1'b0;
        send_gap    = 0;
        recv_stall  = 0;
        gen_prefix  = 0;
        side_reg    = 4'd6;
        count_reg   = '0;
        recov_reg   = 7'd1;
        for (int i = 0; i < rncd_pkg::MAX_CODES; i++) begin
            table_shadow[i] = '0;
            gen_table[i]    = '0;
        end
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset defaults with an empty table: every decode reports nothing found.
        queue_beat(rncd_pkg::OP_DECODE, 10'd0, 64'd0);
        queue_beat(rncd_pkg::OP_DECODE, 10'h3FF, '1);
        // Field extremes on load, including the top slot.
        queue_beat(rncd_pkg::OP_LOAD, 10'd0, 64'd0);
        queue_beat(rncd_pkg::OP_LOAD, 10'd1, '1);
        queue_beat(rncd_pkg::OP_LOAD, 10'd2, 64'hAAAA_AAAA_AAAA_AAAA);
        queue_beat(rncd_pkg::OP_LOAD, 10'd3, 64'h5555_5555_5555_5555);
        queue_beat(rncd_pkg::OP_LOAD, 10'h3FF, rand64());
        for (int i = 4; i < 16; i++)
            queue_beat(rncd_pkg::OP_LOAD, i[9:0], rand64());
        queue_beat(rncd_pkg::OP_DECODE, 10'd0, 64'h1);

        // Sixteen entries, exact hits, turned hits, and bits above the grid.
        set_phase(6, 16, 3);
        queue_beat(rncd_pkg::OP_DECODE, 10'd0, gen_table[5]);
        queue_beat(rncd_pkg::OP_DECODE, 10'd0, quarter_turn(gen_table[7], 6));
        queue_beat(rncd_pkg::OP_DECODE, 10'd0,
                   quarter_turn(quarter_turn(gen_table[9], 6), 6));
        queue_beat(rncd_pkg::OP_DECODE, 10'd0, 64'hFFFF_FFF0_0000_0000);
        queue_beat(rncd_pkg::OP_DECODE, 10'd0, '1);

        // Grid side zero, and a side above eight that acts as eight.
        set_phase(0, 16, 0);
        queue_beat(rncd_pkg::OP_DECODE, 10'd0, rand64());
        set_phase(15, 16, 127);
        queue_beat(rncd_pkg::OP_DECODE, 10'd0, quarter_turn(gen_table[11], 8));
        set_phase(1, 1, 64);
        queue_beat(rncd_pkg::OP_DECODE, 10'd0, 64'h8000_0000_0000_0001);

        // Random phases: mostly small searches so that the run stays short,
        // with loads that both rewrite and extend the written part of the table.
        for (int ph = 0; ph < 18; ph++) begin
            case (ph % 6)
                0:       side = 0;
                1:       side = 8;
                2:       side = $urandom_range(9, 15);
                default: side = $urandom_range(1, 8);
            endcase
            n = (ph == 5) ? gen_prefix : $urandom_range(1, (gen_prefix < 40) ? gen_prefix : 40);
            set_phase(side, n, (ph % 4 == 0) ? 0 : $urandom_range(0, 127));
            for (int i = 0; i < 30; i++) begin
                if ($urandom_range(0, 3) == 0) begin
                    if ($urandom_range(0, 1) == 0 && gen_prefix < rncd_pkg::MAX_CODES)
                        queue_beat(rncd_pkg::OP_LOAD, gen_prefix[9:0], rand64());
                    else
                        queue_beat(rncd_pkg::OP_LOAD,
                                   10'($urandom_range(0, gen_prefix - 1)), rand64());
                end else begin
                    queue_decode_near(n);
                end
            end
        end

        // Quiet tail: extend the written part of the table a little, then
        // search all of it back to back with no idling.
        quiet = 1'b1;
        wait_idle();
        for (int i = 0; i < 10; i++)
            queue_beat(rncd_pkg::OP_LOAD, gen_prefix[9:0], rand64());
        set_phase(8, gen_prefix, 4);
        for (int i = 0; i < 3; i++)
            queue_decode_near(gen_prefix);
        set_phase(7, gen_prefix, 2);
        for (int i = 0; i < 3; i++)
            queue_decode_near(gen_prefix);

        wait_idle();
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("rotated_nearest_codeword_decode_top_tb: clean");
        else
            $display("rotated_nearest_codeword_decode_top_tb: errors");
        $finish;
    end

    // Watchdog far beyond the slowest legal run.
    initial begin
        #20_000_000;
        $display("rotated_nearest_codeword_decode_top_tb: errors");
        $finish;
    end

endmodule
